// ===== sv/pebr_pkg.sv =====
// Shared types, codes and helpers for the PE base relocation fix-up block.
package pebr_pkg;

	typedef enum logic [1:0] {
		ST_FIX       = 2'd0,
		ST_DONE      = 2'd1,
		ST_UNKNOWN   = 2'd2,
		ST_UNALIGNED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_ADD16 = 2'd0,
		KIND_ADD32 = 2'd1,
		KIND_ADD64 = 2'd2,
		KIND_HI20  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_PAGE_LO = 3'd0,
		PH_PAGE_HI = 3'd1,
		PH_SIZE_LO = 3'd2,
		PH_SIZE_HI = 3'd3,
		PH_ENTRY   = 3'd4
	} phase_t;

	localparam logic [1:0] CFG_LOAD_DELTA   = 2'd0;
	localparam logic [1:0] CFG_TABLE_BYTES  = 2'd1;
	localparam logic [1:0] CFG_RISCV_ENABLE = 2'd2;

	localparam logic [3:0] TY_ABSOLUTE = 4'd0;
	localparam logic [3:0] TY_HIGH     = 4'd1;
	localparam logic [3:0] TY_LOW      = 4'd2;
	localparam logic [3:0] TY_HIGHLOW  = 4'd3;
	localparam logic [3:0] TY_HI20     = 4'd5;
	localparam logic [3:0] TY_LOW12I   = 4'd7;
	localparam logic [3:0] TY_LOW12S   = 4'd8;
	localparam logic [3:0] TY_DIR64    = 4'd10;

	localparam logic [31:0] HEADER_BYTES = 32'd8;
	localparam logic [11:0] LOW12_MASK   = 12'hfff;

	typedef struct packed {
		logic        valid;
		status_t     status;
		kind_t       kind;
		logic [31:0] offset;
		logic [63:0] addend;
		logic        last;
	} result_t;

	function automatic result_t mk_result(input status_t st, input kind_t kd,
		input logic [31:0] off, input logic [63:0] add, input logic lst);
		result_t r;
		r.valid  = 1'b1;
		r.status = st;
		r.kind   = kd;
		r.offset = off;
		r.addend = add;
		r.last   = lst;
		return r;
	endfunction

endpackage

// ===== sv/pe_base_relocation_fixup.sv =====
// Top level: PE base relocation table walker that issues fix-up commands.
// One table word is taken per clock cycle, sustained, as long as results are
// consumed; a word reaches the walker through an input register and its
// fix-up, done or error result is loaded into the output register when the
// walker steps that word. The rate is set by the walker's combinational
// header and entry decode. Configure load_delta and riscv_types_enable, then
// write table_bytes to start a run; the run's final result carries last,
// after which words are taken and dropped until table_bytes is written again.
module pe_base_relocation_fixup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] table_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [1:0]  fix_kind,
	output logic [31:0] target_offset,
	output logic [63:0] addend,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import pebr_pkg::*;

	logic [63:0] load_delta_q;
	logic [31:0] table_bytes_q;
	logic        riscv_en_q;
	logic        restart;

	logic        valid_s1;
	logic [15:0] word_s1;
	logic        advance;
	logic        step;
	result_t     res;

	logic        out_valid_q;
	result_t     out_q;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && cfg_index == CFG_TABLE_BYTES;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_delta_q  <= '0;
			table_bytes_q <= '0;
			riscv_en_q    <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOAD_DELTA:   load_delta_q  <= cfg_data;
				CFG_TABLE_BYTES:  table_bytes_q <= cfg_data[31:0];
				CFG_RISCV_ENABLE: riscv_en_q    <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= table_word;
		end
	end

	pebr_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.word        (word_s1),
		.restart     (restart),
		.load_delta  (load_delta_q),
		.table_bytes (table_bytes_q),
		.riscv_en    (riscv_en_q),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step && res.valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign fix_kind      = out_q.kind;
	assign target_offset = out_q.offset;
	assign addend        = out_q.addend;
	assign last          = out_q.last;

endmodule

// ===== sv/pebr_walker.sv =====
// Relocation table walker: header assembly, entry decode and run-end tracking.
module pebr_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [15:0]       word,
	input  logic              restart,
	input  logic [63:0]       load_delta,
	input  logic [31:0]       table_bytes,
	input  logic              riscv_en,
	output pebr_pkg::result_t result
);
	import pebr_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] bp_q, bp_d;
	logic [31:0] page_q, page_d;
	logic [15:0] bsl_q, bsl_d;
	logic [30:0] el_q, el_d;
	logic        ended_q, ended_d;

	phase_t      ph;
	logic [31:0] bp_inc;
	logic        room_now, room_next;
	logic [31:0] off;
	logic [3:0]  typ;
	logic [30:0] el_dec;
	logic        blk_end, ends;
	logic [31:0] size, size_m8;
	logic [30:0] el_new;
	result_t     done_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PAGE_LO;
			bp_q    <= '0;
			page_q  <= '0;
			bsl_q   <= '0;
			el_q    <= '0;
			ended_q <= 1'b0;
		end else if (restart) begin
			phase_q <= PH_PAGE_LO;
			bp_q    <= '0;
			page_q  <= '0;
			bsl_q   <= '0;
			el_q    <= '0;
			ended_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bp_q    <= bp_d;
			page_q  <= page_d;
			bsl_q   <= bsl_d;
			el_q    <= el_d;
			ended_q <= ended_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		bp_d    = bp_q;
		page_d  = page_q;
		bsl_d   = bsl_q;
		el_d    = el_q;
		ended_d = ended_q;
		result  = '0;

		case (phase_q)
			PH_PAGE_HI, PH_SIZE_LO, PH_SIZE_HI, PH_ENTRY: ph = phase_q;
			default:                                      ph = PH_PAGE_LO;
		endcase

		bp_inc    = (bp_q > 32'hffff_fffd) ? 32'hffff_ffff : bp_q + 32'd2;
		room_now  = ({1'b0, bp_q} + {1'b0, HEADER_BYTES}) < {1'b0, table_bytes};
		room_next = ({1'b0, bp_inc} + {1'b0, HEADER_BYTES}) < {1'b0, table_bytes};
		off       = {20'd0, word[11:0] & LOW12_MASK} + page_q;
		typ       = word[15:12];
		el_dec    = el_q - 31'd1;
		blk_end   = (el_dec == '0);
		ends      = blk_end && !room_next;
		size      = {word, bsl_q};
		size_m8   = size - HEADER_BYTES;
		el_new    = (size < HEADER_BYTES) ? '0 : size_m8[31:1];
		done_r    = mk_result(ST_DONE, KIND_ADD16, '0, '0, 1'b1);

		if (step && !ended_q) begin
			if (load_delta == '0) begin
				ended_d = 1'b1;
				result  = done_r;
			end else if (ph == PH_PAGE_LO && !room_now) begin
				phase_d = PH_PAGE_LO;
				ended_d = 1'b1;
				result  = done_r;
			end else begin
				bp_d = bp_inc;
				case (ph)
					PH_PAGE_HI: begin
						page_d  = page_q | {word, 16'd0};
						phase_d = PH_SIZE_LO;
					end
					PH_SIZE_LO: begin
						bsl_d   = word;
						phase_d = PH_SIZE_HI;
					end
					PH_SIZE_HI: begin
						if (size == '0) begin
							ended_d = 1'b1;
							result  = done_r;
						end else begin
							el_d = el_new;
							if (el_new != '0) begin
								phase_d = PH_ENTRY;
							end else begin
								phase_d = PH_PAGE_LO;
								if (!room_next) begin
									ended_d = 1'b1;
									result  = done_r;
								end
							end
						end
					end
					PH_ENTRY: begin
						el_d    = el_dec;
						phase_d = blk_end ? PH_PAGE_LO : PH_ENTRY;
						case (typ)
							TY_ABSOLUTE: begin
								if (ends) begin
									ended_d = 1'b1;
									result  = done_r;
								end
							end
							TY_HIGH: begin
								ended_d = ends;
								result  = mk_result(ST_FIX, KIND_ADD16, off,
									{48'd0, load_delta[31:16]}, ends);
							end
							TY_LOW: begin
								ended_d = ends;
								result  = mk_result(ST_FIX, KIND_ADD16, off,
									{48'd0, load_delta[15:0]}, ends);
							end
							TY_HIGHLOW: begin
								ended_d = ends;
								result  = mk_result(ST_FIX, KIND_ADD32, off,
									{32'd0, load_delta[31:0]}, ends);
							end
							TY_DIR64: begin
								ended_d = ends;
								result  = mk_result(ST_FIX, KIND_ADD64, off, load_delta, ends);
							end
							TY_HI20: begin
								if (!riscv_en) begin
									ended_d = 1'b1;
									result  = mk_result(ST_UNKNOWN, KIND_ADD16, off, '0, 1'b1);
								end else begin
									ended_d = ends;
									result  = mk_result(ST_FIX, KIND_HI20, off,
										{32'd0, load_delta[31:0]}, ends);
								end
							end
							TY_LOW12I, TY_LOW12S: begin
								if (!riscv_en) begin
									ended_d = 1'b1;
									result  = mk_result(ST_UNKNOWN, KIND_ADD16, off, '0, 1'b1);
								end else if ((load_delta[11:0] & LOW12_MASK) != '0) begin
									ended_d = 1'b1;
									result  = mk_result(ST_UNALIGNED, KIND_ADD16, off, '0, 1'b1);
								end else if (ends) begin
									ended_d = 1'b1;
									result  = done_r;
								end
							end
							default: begin
								ended_d = 1'b1;
								result  = mk_result(ST_UNKNOWN, KIND_ADD16, off, '0, 1'b1);
							end
						endcase
					end
					default: begin
						page_d  = {16'd0, word};
						phase_d = PH_PAGE_HI;
					end
				endcase
			end
		end
	end

	a_ended_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |-> !result.valid)
		else $error("result produced after the run ended");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.last && !restart |=> ended_q)
		else $error("run not ended after a last result");

	a_nonfix_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status != ST_FIX |-> result.last && result.addend == '0)
		else $error("done or error result without last or with an addend");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_DONE |-> result.offset == '0)
		else $error("done result carries a target offset");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the PE base relocation fix-up block.
`timescale 1ns / 100ps

module tb_top;
	import pebr_pkg::*;

	localparam int ITEM_TARGET   = 1400;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] table_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [1:0]  fix_kind;
	logic [31:0] target_offset;
	logic [63:0] addend;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	pe_base_relocation_fixup dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.table_word    (table_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.fix_kind      (fix_kind),
		.target_offset (target_offset),
		.addend        (addend),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// walker copy: configuration
	logic [63:0] delta_reg = '0;
	logic [31:0] table_len = '0;
	logic        riscv_on = 1'b0;
	// walker copy: parse state
	logic [31:0] byte_pos = '0;
	phase_t      walk_phase = PH_PAGE_LO;
	logic [31:0] page_base = '0;
	logic [15:0] size_lo = '0;
	logic [30:0] entries_due = '0;
	logic        run_over = 1'b0;

	result_t     pending_cmds[$];
	logic [15:0] table_words[$];
	logic [3:0]  known_types [0:7] = '{TY_ABSOLUTE, TY_HIGH, TY_LOW, TY_HIGHLOW,
		TY_DIR64, TY_HI20, TY_LOW12I, TY_LOW12S};

	int mismatches = 0;
	int live_words = 0;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	function automatic int pick_gap(input bit steady);
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic bit header_blocked();
		return ({1'b0, byte_pos} + {1'b0, HEADER_BYTES}) >= {1'b0, table_len};
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < 50)
			$display("mismatch in %s: got 0x%0h, want 0x%0h at %0t ns", what, got, want,
				$time);
		mismatches++;
	endtask

	task automatic post_cmd(input status_t st, input kind_t kd, input logic [31:0] off,
		input logic [63:0] add, input logic lst);
		result_t cmd;
		cmd.valid  = 1'b1;
		cmd.status = st;
		cmd.kind   = kd;
		cmd.offset = off;
		cmd.addend = add;
		cmd.last   = lst;
		pending_cmds.push_back(cmd);
		run_over = lst;
	endtask

	task automatic close_run();
		post_cmd(ST_DONE, KIND_ADD16, 32'h0, 64'h0, 1'b1);
	endtask

	task automatic walk_table_word(input logic [15:0] w);
		logic [31:0] blk_size;
		logic [31:0] tgt;
		logic        closes;
		live_words++;
		if (!run_over) begin
			if (delta_reg == '0) begin
				close_run();
			end else if (walk_phase == PH_PAGE_LO && header_blocked()) begin
				close_run();
			end else begin
				byte_pos = (byte_pos > 32'hffff_fffd) ? 32'hffff_ffff : byte_pos + 32'd2;
				case (walk_phase)
				PH_PAGE_LO: begin
					page_base  = {16'h0, w};
					walk_phase = PH_PAGE_HI;
				end
				PH_PAGE_HI: begin
					page_base[31:16] = w;
					walk_phase       = PH_SIZE_LO;
				end
				PH_SIZE_LO: begin
					size_lo    = w;
					walk_phase = PH_SIZE_HI;
				end
				PH_SIZE_HI: begin
					blk_size = {w, size_lo};
					if (blk_size == '0) begin
						close_run();
					end else begin
						entries_due = (blk_size < HEADER_BYTES) ? '0 :
							31'((blk_size - HEADER_BYTES) >> 1);
						if (entries_due != '0) begin
							walk_phase = PH_ENTRY;
						end else begin
							walk_phase = PH_PAGE_LO;
							if (header_blocked())
								close_run();
						end
					end
				end
				PH_ENTRY: begin
					tgt         = {20'h0, w[11:0]} + page_base;
					entries_due = entries_due - 31'd1;
					if (entries_due == '0)
						walk_phase = PH_PAGE_LO;
					closes = (walk_phase == PH_PAGE_LO) && header_blocked();
					case (w[15:12])
					TY_ABSOLUTE: begin
						if (closes)
							close_run();
					end
					TY_HIGH:
						post_cmd(ST_FIX, KIND_ADD16, tgt, {48'h0, delta_reg[31:16]}, closes);
					TY_LOW:
						post_cmd(ST_FIX, KIND_ADD16, tgt, {48'h0, delta_reg[15:0]}, closes);
					TY_HIGHLOW:
						post_cmd(ST_FIX, KIND_ADD32, tgt, {32'h0, delta_reg[31:0]}, closes);
					TY_DIR64:
						post_cmd(ST_FIX, KIND_ADD64, tgt, delta_reg, closes);
					TY_HI20: begin
						if (!riscv_on)
							post_cmd(ST_UNKNOWN, KIND_ADD16, tgt, 64'h0, 1'b1);
						else
							post_cmd(ST_FIX, KIND_HI20, tgt, {32'h0, delta_reg[31:0]}, closes);
					end
					TY_LOW12I, TY_LOW12S: begin
						if (!riscv_on)
							post_cmd(ST_UNKNOWN, KIND_ADD16, tgt, 64'h0, 1'b1);
						else if (delta_reg[11:0] != '0)
							post_cmd(ST_UNALIGNED, KIND_ADD16, tgt, 64'h0, 1'b1);
						else if (closes)
							close_run();
					end
					default:
						post_cmd(ST_UNKNOWN, KIND_ADD16, tgt, 64'h0, 1'b1);
					endcase
				end
				default: begin
				end
				endcase
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
		CFG_LOAD_DELTA:   delta_reg = val;
		CFG_TABLE_BYTES: begin
			table_len   = val[31:0];
			byte_pos    = '0;
			walk_phase  = PH_PAGE_LO;
			page_base   = '0;
			size_lo     = '0;
			entries_due = '0;
			run_over    = 1'b0;
		end
		CFG_RISCV_ENABLE: riscv_on = val[0];
		default: begin
		end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input logic [15:0] w);
		int gap;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		table_word <= w;
		do @(posedge clk); while (in_ready !== 1'b1);
		walk_table_word(w);
	endtask

	// hold the sender until every due result is back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_cmds.size() != 0);
	endtask

	// drain, then let words with no result clear the pipeline
	task automatic settle();
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_header(input logic [31:0] page, input logic [31:0] size);
		table_words.push_back(page[15:0]);
		table_words.push_back(page[31:16]);
		table_words.push_back(size[15:0]);
		table_words.push_back(size[31:16]);
	endtask

	task automatic push_entry(input logic [3:0] ty, input logic [11:0] off);
		table_words.push_back({ty, off});
	endtask

	task automatic stream_table(input int pause_at);
		for (int i = 0; i < table_words.size(); i++) begin
			if (i == pause_at)
				hold_until_drained();
			send_word(table_words[i]);
		end
		table_words.delete();
	endtask

	task automatic test_zero_delta();
		table_words.push_back(16'hffff);
		stream_table(-1);
	endtask

	task automatic test_fixup_types();
		settle();
		write_reg(CFG_LOAD_DELTA, 64'hfedc_ba98_7654_3000);
		write_reg(CFG_RISCV_ENABLE, 64'h1);
		write_reg(CFG_TABLE_BYTES, 64'd24);
		push_header(32'hffff_f800, 32'd24);
		push_entry(TY_ABSOLUTE, 12'h000);
		push_entry(TY_HIGH, 12'hfff);
		push_entry(TY_LOW, 12'h800);
		push_entry(TY_HIGHLOW, 12'h7ff);
		push_entry(TY_HI20, 12'h123);
		push_entry(TY_LOW12I, 12'h456);
		push_entry(TY_LOW12S, 12'h789);
		push_entry(TY_DIR64, 12'hffe);
		stream_table(6);
	endtask

	task automatic test_type_errors();
		settle();
		write_reg(CFG_RISCV_ENABLE, 64'h0);
		write_reg(CFG_TABLE_BYTES, 64'hffff_ffff_ffff_ffff);
		push_header(32'h0000_1000, 32'd10);
		push_entry(TY_HI20, 12'h010);
		stream_table(-1);
		settle();
		write_reg(CFG_RISCV_ENABLE, 64'hffff_ffff_ffff_ffff);
		write_reg(CFG_LOAD_DELTA, 64'hffff_ffff_ffff_ffff);
		write_reg(CFG_TABLE_BYTES, 64'd16);
		push_header(32'h0, 32'd16);
		push_entry(TY_DIR64, 12'h000);
		push_entry(TY_LOW12S, 12'h004);
		stream_table(-1);
	endtask

	task automatic test_short_tables();
		settle();
		write_reg(CFG_LOAD_DELTA, 64'h1000);
		write_reg(CFG_TABLE_BYTES, 64'd0);
		table_words.push_back(16'h5a5a);
		stream_table(-1);
		settle();
		write_reg(CFG_TABLE_BYTES, 64'd64);
		push_header(32'h0000_2000, 32'd0);
		stream_table(-1);
	endtask

	task automatic test_random_tables();
		logic [63:0]  cfg_word;
		logic [31:0]  page;
		logic [31:0]  size;
		logic [31:0]  tlen;
		logic [3:0]   ty;
		int unsigned  n;
		int           roll;
		int           pause_at;
		while (live_words < ITEM_TARGET) begin
			settle();
			if ($urandom_range(0, 3) != 0) begin
				roll = $urandom_range(0, 9);
				cfg_word = {$urandom, $urandom};
				if (roll == 0)
					cfg_word = '0;
				else if (roll == 1)
					cfg_word = '1;
				else if (roll < 8)
					cfg_word[11:0] = '0;
				write_reg(CFG_LOAD_DELTA, cfg_word);
			end
			if ($urandom_range(0, 3) != 0) begin
				cfg_word    = {$urandom, $urandom};
				cfg_word[0] = ($urandom_range(0, 3) != 0);
				write_reg(CFG_RISCV_ENABLE, cfg_word);
			end
			repeat ($urandom_range(1, 4)) begin
				page = ($urandom_range(0, 7) == 0) ? (32'hffff_f000 | $urandom_range(0, 4095))
					: $urandom;
				roll = $urandom_range(0, 19);
				if (roll == 0)
					size = 32'd0;
				else if (roll == 1)
					size = $urandom_range(1, 7);
				else if (roll == 2)
					size = 32'd9 + 32'd2 * $urandom_range(0, 8);
				else if (roll == 3)
					size = $urandom;
				else
					size = 32'd8 + 32'd2 * $urandom_range(0, 10);
				push_header(page, size);
				n = (size >= HEADER_BYTES) ? (size - HEADER_BYTES) / 2 : 0;
				if (n > 12)
					n = 12;
				repeat (n) begin
					ty = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(0, 15))
						: known_types[$urandom_range(0, 7)];
					push_entry(ty, 12'($urandom_range(0, 4095)));
				end
			end
			tlen = table_words.size() * 2;
			roll = $urandom_range(0, 19);
			if (roll < 10)
				tlen = tlen;
			else if (roll < 13)
				tlen = tlen + $urandom_range(1, 12);
			else if (roll < 15)
				tlen = tlen - $urandom_range(1, 8);
			else if (roll < 17)
				tlen = 32'hffff_ffff;
			else if (roll == 17)
				tlen = 32'h0;
			else
				tlen = $urandom;
			cfg_word       = {$urandom, $urandom};
			cfg_word[31:0] = tlen;
			write_reg(CFG_TABLE_BYTES, cfg_word);
			repeat ($urandom_range(0, 2))
				table_words.push_back(16'($urandom_range(0, 65535)));
			tx_steady = ($urandom_range(0, 3) == 0);
			pause_at  = ($urandom_range(0, 9) == 0) ?
				$urandom_range(0, table_words.size() - 1) : -1;
			stream_table(pause_at);
		end
		tx_steady = 1'b0;
	endtask

	always @(posedge clk) begin : result_side
		result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_cmds.size() == 0) begin
				report_mismatch("transaction with no command due", {62'h0, status}, 64'h0);
			end else begin
				want = pending_cmds.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (fix_kind !== want.kind)
					report_mismatch("fix_kind", 64'(fix_kind), 64'(want.kind));
				if (target_offset !== want.offset)
					report_mismatch("target_offset", 64'(target_offset), 64'(want.offset));
				if (addend !== want.addend)
					report_mismatch("addend", addend, want.addend);
				if (last !== want.last)
					report_mismatch("last", 64'(last), 64'(want.last));
			end
		end
		if ($urandom_range(0, 299) == 0)
			rx_steady = !rx_steady;
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 2) == 0)
				stall_left = pick_gap(rx_steady);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_delta();
		test_fixup_types();
		test_type_errors();
		test_short_tables();
		test_random_tables();
		settle();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/pebr_pkg.sv
sv/pebr_walker.sv
sv/pe_base_relocation_fixup.sv
dv/tb_top.sv
